@@ design/icmpeb_pkg.sv @@
// ----------------------------------------------------------------------------
// icmpeb_pkg
// Shared types and constants for the ICMP echo request builder.
// ----------------------------------------------------------------------------
`default_nettype none

package icmpeb_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_PAYLOAD_DEF = 484;
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned WORD_BYTES_DEF  = 8;

  localparam int unsigned HDR_BYTES = 28;  // IP header plus ICMP header
  localparam int unsigned TS_BYTES  = 16;  // seconds and microseconds, 8 each
  localparam int unsigned TS_MIN_PAYLOAD = 16;

  // header constants
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [15:0] IP_IDENT      = 16'd42;
  localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
  // fixed IP header words folded together: 0x4500 + identification
  localparam logic [15:0] IP_CK_FIXED   = {IP_VER_IHL, 8'h00} + IP_IDENT;
  // type and code word that seeds the ICMP sum
  localparam logic [15:0] ICMP_CK_SEED  = {ICMP_ECHO_REQ, 8'h00};

  // last term of each header sum sequence
  localparam logic [2:0] TC_IP_LAST = 3'd4;
  localparam logic [2:0] TC_IC_LAST = 3'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAY_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI   = 3'd6;

  typedef struct packed {
    logic [62:0] time_seconds;
    logic [19:0] time_microseconds;
  } in_item_t;

  typedef struct packed {
    logic [63:0] packet_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IPCK,   // IP header checksum terms
    ST_PAYCK,  // payload checksum pass, one byte per cycle
    ST_ICK,    // ICMP id and sequence terms
    ST_EMIT    // packet out, one byte per cycle unless the output stalls
  } state_t;

  // payload byte generator control
  typedef struct packed {
    logic load;     // capture timestamp
    logic restart;  // back to payload byte 0
    logic step;     // advance one payload byte
  } pay_ctl_t;

endpackage

`default_nettype wire

@@ design/icmpeb_pay_gen.sv @@
// ----------------------------------------------------------------------------
// icmpeb_pay_gen
// Payload byte source: timestamp bytes from a rotating register when ts_en is set,
// then the pattern in reverse order, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpeb_pay_gen (
  input  wire                     clk,
  input  wire                     rst_n,
  input  icmpeb_pkg::pay_ctl_t    ctl,
  input  icmpeb_pkg::in_item_t    ts_in,
  input  wire  [4:0]              plen,     // clamped, 1..16
  input  wire                     ts_en,    // payload carries timestamp
  input  wire  [127:0]            pattern,
  output logic [7:0]              pay_byte
);
  import icmpeb_pkg::*;

  logic [127:0] ts_r, ts_nxt;
  logic [3:0]   pidx_r, pidx_nxt;
  logic [4:0]   tcnt_r, tcnt_nxt;
  logic [3:0]   plen_m1;

  assign plen_m1 = 4'(plen - 5'd1);

  always_comb begin
    ts_nxt   = ts_r;
    pidx_nxt = pidx_r;
    tcnt_nxt = tcnt_r;
    if (ctl.load) begin
      ts_nxt = {44'd0, ts_in.time_microseconds, 1'b0, ts_in.time_seconds};
    end
    if (ctl.restart) begin
      pidx_nxt = plen_m1;
      tcnt_nxt = '0;
    end else if (ctl.step) begin
      pidx_nxt = (pidx_r == 4'd0) ? plen_m1 : pidx_r - 4'd1;
      if (tcnt_r < 5'(TS_BYTES)) begin
        tcnt_nxt = tcnt_r + 5'd1;
        // rotate so sixteen steps bring the register back for the next pass
        ts_nxt   = {ts_r[7:0], ts_r[127:8]};
      end
    end
  end

  always_ff @(posedge clk) begin
    ts_r <= ts_nxt;
    if (!rst_n) begin
      pidx_r <= '0;
      tcnt_r <= '0;
    end else begin
      pidx_r <= pidx_nxt;
      tcnt_r <= tcnt_nxt;
    end
  end

  assign pay_byte = (ts_en && (tcnt_r < 5'(TS_BYTES))) ? ts_r[7:0]
                                                     : pattern[{pidx_r, 3'b000} +: 8];

endmodule

`default_nettype wire

@@ design/icmp_echo_request_builder_core.sv @@
// ----------------------------------------------------------------------------
// icmp_echo_request_builder_core: one IPv4 ICMP echo request per input beat.
// Order of work after accept: IP header sum, a byte-serial checksum pass
//   over the payload (skipped when empty), ICMP id and sequence terms, then
//   byte-serial emit of the packet words.
// Requests are taken only in idle; the checksum pass takes one byte per
//   cycle, the word assembler one byte per cycle when the output is not stalled.
// Reset: synchronous, clears sequence counter, restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_request_builder_core #(
  parameter int unsigned MAX_PAYLOAD = icmpeb_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned MAX_PATTERN = icmpeb_pkg::MAX_PATTERN_DEF,
  parameter int unsigned WORD_BYTES  = icmpeb_pkg::WORD_BYTES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // request channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  icmpeb_pkg::in_item_t                 in_data,
  // packet word channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output icmpeb_pkg::out_item_t                out_data,
  // configuration writes
  input  wire                                  cfg_we,
  input  wire  [icmpeb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [63:0]                          cfg_wdata
);
  import icmpeb_pkg::*;

  localparam int unsigned BC_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  // configuration registers
  logic [7:0]   ttl_r;
  logic [31:0]  dest_r;
  logic [15:0]  echo_id_r;
  logic [8:0]   pay_size_r;
  logic [4:0]   pat_len_r;
  logic [63:0]  pat_lo_r;
  logic [63:0]  pat_hi_r;

  // control and datapath
  state_t       state_r, state_nxt;
  logic [15:0]  seq_r, seq_nxt;
  logic [8:0]   size_r, size_nxt;     // clamped payload size of this packet
  logic [4:0]   plen_r, plen_nxt;     // clamped pattern length
  logic [2:0]   tc_r, tc_nxt;         // header term counter
  logic [9:0]   pos_r, pos_nxt;       // byte position in pass
  logic [15:0]  acc_r, acc_nxt;       // ones-complement accumulator
  logic [15:0]  ipck_r, ipck_nxt;
  logic [15:0]  icck_r, icck_nxt;
  logic [63:0]  sh_r, sh_nxt;         // word assembly
  logic [BC_W-1:0] bc_r, bc_nxt;      // byte slot in the word
  out_item_t    out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic         accept;
  logic [8:0]   size_c;
  logic [4:0]   plen_c;
  logic [9:0]   total;
  logic [15:0]  term;
  logic [16:0]  sum17;
  logic [15:0]  add_res;
  logic [7:0]   pay_byte;
  logic [7:0]   hdr_byte;
  logic [7:0]   emit_byte;
  logic [63:0]  sh_ins;
  logic         is_last;
  logic         closing;
  logic         can_close;
  logic         adv;
  pay_ctl_t     gen_ctl;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // request-time clamps
  always_comb begin
    size_c = (pay_size_r > 9'(MAX_PAYLOAD)) ? 9'(MAX_PAYLOAD) : pay_size_r;
    if (pat_len_r == 5'd0) begin
      plen_c = 5'd1;
    end else if (pat_len_r > 5'(MAX_PATTERN)) begin
      plen_c = 5'(MAX_PATTERN);
    end else begin
      plen_c = pat_len_r;
    end
  end

  assign total = {1'b0, size_r} + 10'(HDR_BYTES);

  // shared end-around-carry adder for both checksums
  assign sum17   = {1'b0, acc_r} + {1'b0, term};
  assign add_res = sum17[15:0] + 16'(sum17[16]);

  icmpeb_pay_gen u_pay_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (gen_ctl),
    .ts_in    (in_data),
    .plen     (plen_r),
    .ts_en    (size_r >= 9'(TS_MIN_PAYLOAD)),
    .pattern  ({pat_hi_r, pat_lo_r}),
    .pay_byte (pay_byte)
  );

  // header byte at the current wire position
  always_comb begin
    case (pos_r[4:0])
      5'd0:    hdr_byte = IP_VER_IHL;
      5'd2:    hdr_byte = {6'd0, total[9:8]};
      5'd3:    hdr_byte = total[7:0];
      5'd4:    hdr_byte = IP_IDENT[15:8];
      5'd5:    hdr_byte = IP_IDENT[7:0];
      5'd8:    hdr_byte = ttl_r;
      5'd9:    hdr_byte = IP_PROTO_ICMP;
      5'd10:   hdr_byte = ipck_r[15:8];
      5'd11:   hdr_byte = ipck_r[7:0];
      5'd16:   hdr_byte = dest_r[31:24];
      5'd17:   hdr_byte = dest_r[23:16];
      5'd18:   hdr_byte = dest_r[15:8];
      5'd19:   hdr_byte = dest_r[7:0];
      5'd20:   hdr_byte = ICMP_ECHO_REQ;
      5'd22:   hdr_byte = icck_r[15:8];
      5'd23:   hdr_byte = icck_r[7:0];
      5'd24:   hdr_byte = echo_id_r[7:0];     // id and sequence go out little-endian
      5'd25:   hdr_byte = echo_id_r[15:8];
      5'd26:   hdr_byte = seq_r[7:0];
      5'd27:   hdr_byte = seq_r[15:8];
      default: hdr_byte = 8'h00;              // TOS, flags, source address, ICMP code
    endcase
  end

  assign emit_byte = (pos_r < 10'(HDR_BYTES)) ? hdr_byte : pay_byte;
  assign is_last   = (pos_r == total - 10'd1);
  assign closing   = (bc_r == BC_W'(WORD_BYTES - 1)) || is_last;
  assign can_close = !out_valid_r || !out_stall;
  assign adv       = !closing || can_close;

  always_comb begin
    sh_ins = sh_r;
    sh_ins[{bc_r, 3'b000} +: 8] = emit_byte;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_IPCK;
      end
      ST_IPCK: begin
        if (tc_r == TC_IP_LAST) state_nxt = (size_r != 9'd0) ? ST_PAYCK : ST_ICK;
      end
      ST_PAYCK: begin
        if (pos_r == {1'b0, size_r} - 10'd1) state_nxt = ST_ICK;
      end
      ST_ICK: begin
        if (tc_r == TC_IC_LAST) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (adv && is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    seq_nxt       = seq_r;
    size_nxt      = size_r;
    plen_nxt      = plen_r;
    tc_nxt        = tc_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    ipck_nxt      = ipck_r;
    icck_nxt      = icck_r;
    sh_nxt        = sh_r;
    bc_nxt        = bc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    gen_ctl       = '0;
    term          = 16'h0000;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          size_nxt     = size_c;
          plen_nxt     = plen_c;
          tc_nxt       = '0;
          acc_nxt      = '0;
          gen_ctl.load = 1'b1;
        end
      end
      ST_IPCK: begin
        case (tc_r)
          3'd0:    term = IP_CK_FIXED;
          3'd1:    term = {6'd0, total};
          3'd2:    term = {ttl_r, IP_PROTO_ICMP};
          3'd3:    term = dest_r[31:16];
          3'd4:    term = dest_r[15:0];
          default: term = 16'h0000;
        endcase
        acc_nxt = add_res;
        tc_nxt  = tc_r + 3'd1;
        if (tc_r == TC_IP_LAST) begin
          ipck_nxt        = ~add_res;
          acc_nxt         = ICMP_CK_SEED;
          tc_nxt          = '0;
          pos_nxt         = '0;
          gen_ctl.restart = 1'b1;
        end
      end
      ST_PAYCK: begin
        // even payload bytes are the high half of a 16-bit word
        term         = pos_r[0] ? {8'h00, pay_byte} : {pay_byte, 8'h00};
        acc_nxt      = add_res;
        pos_nxt      = pos_r + 10'd1;
        gen_ctl.step = 1'b1;
      end
      ST_ICK: begin
        term    = (tc_r == 3'd0) ? {echo_id_r[7:0], echo_id_r[15:8]}
                                 : {seq_r[7:0], seq_r[15:8]};
        acc_nxt = add_res;
        tc_nxt  = tc_r + 3'd1;
        if (tc_r == TC_IC_LAST) begin
          icck_nxt        = ~add_res;
          tc_nxt          = '0;
          pos_nxt         = '0;
          bc_nxt          = '0;
          sh_nxt          = '0;
          gen_ctl.restart = 1'b1;
        end
      end
      ST_EMIT: begin
        if (adv) begin
          pos_nxt      = pos_r + 10'd1;
          gen_ctl.step = (pos_r >= 10'(HDR_BYTES));
          if (closing) begin
            out_nxt.packet_word = sh_ins;
            out_nxt.valid_bytes = 4'(bc_r) + 4'd1;
            out_nxt.last_word   = is_last;
            out_valid_nxt       = 1'b1;
            sh_nxt              = '0;   // unused bytes of a short word stay zero
            bc_nxt              = '0;
          end else begin
            sh_nxt = sh_ins;
            bc_nxt = bc_r + BC_W'(1);
          end
          if (is_last) seq_nxt = seq_r + 16'd1;
        end
      end
      default: begin
        gen_ctl = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r      <= 8'd255;
      dest_r     <= '0;
      echo_id_r  <= '0;
      pay_size_r <= 9'd56;
      pat_len_r  <= 5'd1;
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TTL:      ttl_r      <= cfg_wdata[7:0];
        CFG_DEST:     dest_r     <= cfg_wdata[31:0];
        CFG_ECHO_ID:  echo_id_r  <= cfg_wdata[15:0];
        CFG_PAY_SIZE: pay_size_r <= cfg_wdata[8:0];
        CFG_PAT_LEN:  pat_len_r  <= cfg_wdata[4:0];
        CFG_PAT_LO:   pat_lo_r   <= cfg_wdata;
        CFG_PAT_HI:   pat_hi_r   <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    plen_r <= plen_nxt;
    acc_r  <= acc_nxt;
    ipck_r <= ipck_nxt;
    icck_r <= icck_nxt;
    out_r  <= out_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seq_r       <= '0;
      tc_r        <= '0;
      pos_r       <= '0;
      sh_r        <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      tc_r        <= tc_nxt;
      pos_r       <= pos_nxt;
      sh_r        <= sh_nxt;
      bc_r        <= bc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_IPCK))
    else $error("accepted request did not start the header sum");

  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last_word) |-> (out_r.valid_bytes == 4'(WORD_BYTES)))
    else $error("non-final word is not full");

  a_seq_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(seq_r)) |-> $past(state_r == ST_EMIT))
    else $error("sequence counter moved outside packet emit");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r < total))
    else $error("emit position past end of packet");

endmodule

`default_nettype wire

@@ test/icmp_echo_checker.sv @@
// ----------------------------------------------------------------------------
// icmp_echo_checker
// Watches the request, packet word and register channels of the echo request
// builder, predicts every packet word and compares it with what comes out.
// ----------------------------------------------------------------------------
module icmp_echo_checker (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  input  wire                               in_stall,
  input  icmpeb_pkg::in_item_t              in_data,
  input  wire                               out_valid,
  input  wire                               out_stall,
  input  icmpeb_pkg::out_item_t             out_data,
  input  wire                               cfg_we,
  input  wire  [icmpeb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [63:0]                       cfg_wdata,
  output int                                mismatch_count,
  output int                                words_pending
);
  import icmpeb_pkg::*;

  // shadow registers and sequence state
  logic [7:0]  ttl_r;
  logic [31:0] dest_r;
  logic [15:0] echo_id_r;
  logic [8:0]  pay_size_r;
  logic [4:0]  pat_len_r;
  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;
  logic [15:0] seq_r;

  logic [7:0]  pkt_img [0:511];
  out_item_t   expected_words [$];
  out_item_t   want;
  int          tally = 0;

  assign mismatch_count = tally;

  function automatic logic [15:0] inet_checksum(int unsigned first, int unsigned len);
    logic [31:0] acc;
    int unsigned i;
    acc = '0;
    for (i = 0; i + 1 < len; i += 2)
      acc += {16'h0, pkt_img[first + i], pkt_img[first + i + 1]};
    if (len % 2 != 0)
      acc += {16'h0, pkt_img[first + len - 1], 8'h00};
    while (acc[31:16] != 0)
      acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned k);
    if (k < 8)
      return pat_lo_r[8 * k +: 8];
    return pat_hi_r[8 * (k - 8) +: 8];
  endfunction

  function automatic void build_echo_packet(in_item_t req);
    int unsigned size, plen, total, i, k, cnt;
    logic [15:0] tot16, ck;
    logic [63:0] secs, usec;
    out_item_t w;
    size = (pay_size_r > 9'(MAX_PAYLOAD_DEF)) ? MAX_PAYLOAD_DEF : 32'(pay_size_r);
    plen = (pat_len_r == 5'd0) ? 1 :
           ((pat_len_r > 5'(MAX_PATTERN_DEF)) ? MAX_PATTERN_DEF : 32'(pat_len_r));
    total = HDR_BYTES + size;
    tot16 = total[15:0];
    for (i = 0; i < 512; i++)
      pkt_img[i] = 8'h00;

    // IP header
    pkt_img[0]  = IP_VER_IHL;
    pkt_img[2]  = tot16[15:8];
    pkt_img[3]  = tot16[7:0];
    pkt_img[4]  = IP_IDENT[15:8];
    pkt_img[5]  = IP_IDENT[7:0];
    pkt_img[8]  = ttl_r;
    pkt_img[9]  = IP_PROTO_ICMP;
    pkt_img[16] = dest_r[31:24];
    pkt_img[17] = dest_r[23:16];
    pkt_img[18] = dest_r[15:8];
    pkt_img[19] = dest_r[7:0];
    ck = inet_checksum(0, 20);
    pkt_img[10] = ck[15:8];
    pkt_img[11] = ck[7:0];

    // payload: reversed pattern, timestamp on top when there is room
    for (i = 0; i < size; i++)
      pkt_img[HDR_BYTES + i] = pattern_at(plen - 1 - (i % plen));
    if (size >= TS_MIN_PAYLOAD) begin
      secs = {1'b0, req.time_seconds};
      usec = {44'h0, req.time_microseconds};
      for (k = 0; k < 8; k++) begin
        pkt_img[HDR_BYTES + k]     = secs[8 * k +: 8];
        pkt_img[HDR_BYTES + 8 + k] = usec[8 * k +: 8];
      end
    end

    // ICMP header, id and sequence little-endian
    pkt_img[20] = ICMP_ECHO_REQ;
    pkt_img[24] = echo_id_r[7:0];
    pkt_img[25] = echo_id_r[15:8];
    pkt_img[26] = seq_r[7:0];
    pkt_img[27] = seq_r[15:8];
    seq_r = seq_r + 16'd1;
    ck = inet_checksum(20, 8 + size);
    pkt_img[22] = ck[15:8];
    pkt_img[23] = ck[7:0];

    for (i = 0; i < total; i += WORD_BYTES_DEF) begin
      cnt = (total - i > WORD_BYTES_DEF) ? WORD_BYTES_DEF : total - i;
      w = '0;
      for (k = 0; k < cnt; k++)
        w.packet_word[8 * k +: 8] = pkt_img[i + k];
      w.valid_bytes = cnt[3:0];
      w.last_word   = (i + cnt >= total);
      expected_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ttl_r      = 8'd255;
      dest_r     = '0;
      echo_id_r  = '0;
      pay_size_r = 9'd56;
      pat_len_r  = 5'd1;
      pat_lo_r   = '0;
      pat_hi_r   = '0;
      seq_r      = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TTL:      ttl_r      = cfg_wdata[7:0];
          CFG_DEST:     dest_r     = cfg_wdata[31:0];
          CFG_ECHO_ID:  echo_id_r  = cfg_wdata[15:0];
          CFG_PAY_SIZE: pay_size_r = cfg_wdata[8:0];
          CFG_PAT_LEN:  pat_len_r  = cfg_wdata[4:0];
          CFG_PAT_LO:   pat_lo_r   = cfg_wdata;
          CFG_PAT_HI:   pat_hi_r   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected packet beat %h", out_data.packet_word);
          tally++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.packet_word !== want.packet_word) begin
            $error("packet_word: expected %h, got %h", want.packet_word,
                   out_data.packet_word);
            tally++;
          end
          if (out_data.valid_bytes !== want.valid_bytes) begin
            $error("valid_bytes: expected %0d, got %0d", want.valid_bytes,
                   out_data.valid_bytes);
            tally++;
          end
          if (out_data.last_word !== want.last_word) begin
            $error("last_word: expected %b, got %b", want.last_word,
                   out_data.last_word);
            tally++;
          end
        end
      end
      if (in_valid && !in_stall)
        build_echo_packet(in_data);
    end
    words_pending <= expected_words.size();
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives send requests and register writes into the echo request builder,
// with random gaps and back-pressure; the checker beside it does the scoring.
// ----------------------------------------------------------------------------
module testbench;
  import icmpeb_pkg::*;

  localparam int IDLE_LIMIT   = 8000;
  localparam int TARGET_ITEMS = 450;
  localparam logic [62:0] SECS_MAX = {63{1'b1}};
  localparam logic [19:0] USEC_MAX = 20'd999999;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TTL;
  logic [63:0]          cfg_wdata = '0;

  int          mismatches;
  int          words_pending;
  int          requests_sent = 0;
  int          idle_cycles = 0;
  bit          calm_in = 1'b0;   // no request gaps while set
  bit          calm_out = 1'b0;  // no back-pressure while set
  int unsigned stall_left = 0;
  int unsigned stall_draw;

  always #10 clk = ~clk;

  icmp_echo_request_builder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  icmp_echo_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .words_pending  (words_pending)
  );

  // Back-pressure: after each accepted beat, draw how long to hold stall.
  // Stall may already be up when the next word shows, so gaps land anywhere
  // in the byte-serial emit.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = calm_out ? 0 : $urandom_range(0, 9);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [62:0] rand_secs();
    logic [63:0] r;
    r = rand64();
    return r[62:0];
  endfunction

  function automatic logic [19:0] rand_usec();
    return 20'($urandom_range(0, 999999));
  endfunction

  // One register write per edge; cfg_we stays up across back-to-back writes
  // and the caller drops it once the batch is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [7:0] ttl_v, logic [31:0] dest_v, logic [15:0] id_v,
                              logic [8:0] size_v, logic [4:0] plen_v,
                              logic [63:0] lo_v, logic [63:0] hi_v);
    write_reg(CFG_TTL, {56'h0, ttl_v});
    write_reg(CFG_DEST, {32'h0, dest_v});
    write_reg(CFG_ECHO_ID, {48'h0, id_v});
    write_reg(CFG_PAY_SIZE, {55'h0, size_v});
    write_reg(CFG_PAT_LEN, {59'h0, plen_v});
    write_reg(CFG_PAT_LO, lo_v);
    write_reg(CFG_PAT_HI, hi_v);
    cfg_we <= 1'b0;
  endtask

  // Present one request beat and return on the edge that accepts it. Valid
  // is left high so a zero gap keeps the next beat back to back.
  task automatic issue_request(logic [62:0] secs, logic [19:0] usec);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_data.time_seconds      <= secs;
    in_data.time_microseconds <= usec;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Drop valid and wait until every predicted word has been seen, so the
  // block is back at idle before any register changes.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic send_random();
    logic [62:0] secs;
    logic [19:0] usec;
    case ($urandom_range(0, 7))
      0:       secs = '0;
      1:       secs = SECS_MAX;
      default: secs = rand_secs();
    endcase
    case ($urandom_range(0, 7))
      0:       usec = '0;
      1:       usec = USEC_MAX;
      default: usec = rand_usec();
    endcase
    issue_request(secs, usec);
  endtask

  initial begin
    int          n_items;
    bit          big;
    logic [8:0]  size_v;
    logic [4:0]  plen_v;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ----------------------------------------------------
    // Defaults after reset: 56 byte payload, one zero pattern byte.
    issue_request('0, '0);
    issue_request(SECS_MAX, USEC_MAX);
    drain();

    // Empty payload, zero pattern length and TTL, all-ones address, id and pattern.
    program_regs(8'h00, 32'hFFFF_FFFF, 16'hFFFF, 9'd0, 5'd0, {64{1'b1}}, {64{1'b1}});
    issue_request(rand_secs(), rand_usec());
    drain();

    // Single payload byte: odd checksum length, partial last word.
    program_regs(8'hFF, 32'h0, 16'h0, 9'd1, 5'd1, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();

    // Short payloads with no timestamp; pattern cut off at payload end.
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd7, 5'd3, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd15, 5'd16, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd5, 5'd16, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();

    // Timestamp threshold and oversized pattern lengths.
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd16, 5'd17, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd17, 5'd31, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();

    // Largest payload, alternating bits in pattern and timestamp.
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd484, 5'd16,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_request({1'b1, {31{2'b01}}}, 20'h55555);
    issue_request({1'b0, {31{2'b10}}}, 20'hAAAAA);
    drain();

    // Payload sizes past the maximum get clamped.
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd511, 5'd7, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd485, 5'd9, rand64(), rand64());
    issue_request(rand_secs(), rand_usec());
    drain();

    // Back-to-back requests with no idling on either side.
    calm_in  = 1'b1;
    calm_out = 1'b1;
    program_regs(8'($urandom), $urandom, 16'($urandom), 9'd20, 5'd2, rand64(), rand64());
    issue_request('0, USEC_MAX);
    issue_request(SECS_MAX, '0);
    issue_request(rand_secs(), rand_usec());
    drain();

    // --- random part ------------------------------------------------------
    // Phases of random register changes; most use small payloads, a few go
    // to the largest sizes with only a handful of requests.
    while (requests_sent < TARGET_ITEMS) begin
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      big = ($urandom_range(0, 11) == 0);
      case ($urandom_range(0, 9))
        0:       size_v = 9'($urandom_range(0, 15));
        1:       size_v = 9'($urandom_range(65, 200));
        default: size_v = 9'($urandom_range(0, 64));
      endcase
      if (big)
        size_v = 9'($urandom_range(400, 511));
      plen_v = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 16));

      if ($urandom_range(0, 1))
        write_reg(CFG_TTL, ($urandom_range(0, 3) == 0) ? {56'h0, 8'hFF} : {56'h0, 8'($urandom)});
      if ($urandom_range(0, 1))
        write_reg(CFG_DEST, {32'h0, $urandom});
      if ($urandom_range(0, 1))
        write_reg(CFG_ECHO_ID, {48'h0, 16'($urandom)});
      write_reg(CFG_PAY_SIZE, {55'h0, size_v});
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_PAT_LEN, {59'h0, plen_v});
      if ($urandom_range(0, 1))
        write_reg(CFG_PAT_LO, rand64());
      if ($urandom_range(0, 1))
        write_reg(CFG_PAT_HI, rand64());
      cfg_we <= 1'b0;

      n_items = big ? $urandom_range(1, 3) : $urandom_range(8, 40);
      repeat (n_items) send_random();
      drain();
    end

    // Settle before the final check, so a stray word that sneaks out is caught.
    repeat (600) @(posedge clk);
    if (mismatches == 0 && words_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
design/icmpeb_pkg.sv
design/icmpeb_pay_gen.sv
design/icmp_echo_request_builder_core.sv
test/icmp_echo_checker.sv
test/testbench.sv
